// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define OLPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication
`define OLPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ===== rtl/core/olpi_pkg.sv =====
`timescale 1ns / 1ps
package olpi_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int OP_W        = 2;
  localparam int VAL_W       = 16;
  localparam int POS_W       = 8;
  localparam int IDX_OUT_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_FRONT = 2'd0,
    OP_END   = 2'd1,
    OP_POS   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic insert;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_hold;
    logic last;
  } stat_t;

endpackage

// ===== rtl/core/olpi_in_if.sv =====
`timescale 1ns / 1ps
interface olpi_in_if;
  import olpi_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VAL_W-1:0] item_value;
  logic [POS_W-1:0] insert_pos;

  modport source (output valid, output opcode, output item_value, output insert_pos,
                  input ready);
  modport sink (input valid, input opcode, input item_value, input insert_pos,
                output ready);
endinterface

// ===== rtl/core/olpi_out_if.sv =====
`timescale 1ns / 1ps
interface olpi_out_if;
  import olpi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     elem_value;
  logic [IDX_OUT_W-1:0] elem_index;
  logic                 last_elem;
  logic                 insert_rejected;

  modport source (output valid, output elem_value, output elem_index, output last_elem,
                  output insert_rejected, input ready);
  modport sink (input valid, input elem_value, input elem_index, input last_elem,
                input insert_rejected, output ready);
endinterface

// ===== rtl/core/olpi_ctrl.sv =====
`timescale 1ns / 1ps
module olpi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  olpi_pkg::stat_t stat,
  output olpi_pkg::cmd_t  cmd
);
  import olpi_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // leave once the final element sits in the output register
        if (!stat.out_hold && stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.insert  = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_EMIT: begin
        cmd.load = !stat.out_hold;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/olpi_dp.sv =====
`timescale 1ns / 1ps
module olpi_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  olpi_pkg::cmd_t                 cmd,
  output olpi_pkg::stat_t                stat,
  input  logic [olpi_pkg::OP_W-1:0]      in_opcode,
  input  logic [olpi_pkg::VAL_W-1:0]     in_item_value,
  input  logic [olpi_pkg::POS_W-1:0]     in_insert_pos,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [olpi_pkg::VAL_W-1:0]     out_elem_value,
  output logic [olpi_pkg::IDX_OUT_W-1:0] out_elem_index,
  output logic                           out_last_elem,
  output logic                           out_insert_rejected
);
  import olpi_pkg::*;

  // usable depth saturates at the width of elem_index
  localparam int EFF_CAP = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;
  localparam int IDX_W   = $clog2(EFF_CAP);
  localparam int CNT_W   = $clog2(EFF_CAP + 1);

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r;
  logic [VAL_W-1:0] store_r [EFF_CAP];
  logic             rej_r;
  logic [IDX_W-1:0] emit_idx_r;

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic                 out_last_r;
  logic                 out_rej_r;

  logic             full;
  logic             ins_en;
  logic [CNT_W-1:0] ins_pos;
  logic             last;

  assign full   = (count_r == CNT_W'(EFF_CAP));
  assign ins_en = cmd.insert && !full;
  assign last   = ((CNT_W'(emit_idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    unique case (op_r)
      OP_FRONT: ins_pos = '0;
      OP_END:   ins_pos = count_r;
      default: begin
        // positional, also the unused code
        if (pos_r >= POS_W'(count_r)) begin
          ins_pos = count_r;
        end else begin
          ins_pos = pos_r[CNT_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_item_value;
      pos_r <= in_insert_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ins_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // each entry takes the new word, its lower neighbor, or holds
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (ins_pos == '0) begin
        store_r[0] <= val_r;
      end
      for (int i = 1; i < EFF_CAP; i++) begin
        if (CNT_W'(i) == ins_pos) begin
          store_r[i] <= val_r;
        end else if (CNT_W'(i) > ins_pos && CNT_W'(i) <= count_r) begin
          store_r[i] <= store_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      rej_r <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.insert) begin
      emit_idx_r <= '0;
    end else if (cmd.load) begin
      emit_idx_r <= emit_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r <= store_r[emit_idx_r];
      out_index_r <= IDX_OUT_W'(emit_idx_r);
      out_last_r  <= last;
      out_rej_r   <= rej_r;
    end
  end

  assign stat.out_hold = out_valid_r && !out_ready;
  assign stat.last     = last;

  assign out_valid           = out_valid_r;
  assign out_elem_value      = out_value_r;
  assign out_elem_index      = out_index_r;
  assign out_last_elem       = out_last_r;
  assign out_insert_rejected = out_rej_r;

endmodule

// ===== rtl/core/ordered_list_positional_insert.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake        word
// in_ch     in   valid / ready    opcode, item_value, insert_pos
// out_ch    out  valid / ready    elem_value, elem_index, last_elem, insert_rejected
//
// for a list of n elements after the insert, one word runs through accept, the parallel
// shift-insert, then one output-register load per element
// the final element may still wait in the output register while the next word is taken
// a stall on out_ch holds the listing in place; in_ch is ready only between listings
// rst_n is synchronous; it empties the list, element values are not cleared
module ordered_list_positional_insert #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  olpi_in_if.sink    in_ch,
  olpi_out_if.source out_ch
);
  import olpi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  olpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olpi_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_ch.opcode),
    .in_item_value       (in_ch.item_value),
    .in_insert_pos       (in_ch.insert_pos),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_elem_value      (out_ch.elem_value),
    .out_elem_index      (out_ch.elem_index),
    .out_last_elem       (out_ch.last_elem),
    .out_insert_rejected (out_ch.insert_rejected)
  );

endmodule

// ===== rtl/core/olpi_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module olpi_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [olpi_pkg::IDX_OUT_W-1:0] out_elem_index,
  input logic                           out_last_elem
);
  import olpi_pkg::*;

  // a stalled word keeps its place in the listing
  `OLPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_elem_index))

  // listing runs without gaps, index counting up
  `OLPI_ASSERT_NEXT(a_out_next, out_valid && out_ready && !out_last_elem,
    out_valid && out_elem_index == IDX_OUT_W'($past(out_elem_index) + 1'b1))

  // whatever follows the final element starts a new listing
  `OLPI_ASSERT_NEXT(a_out_restart, out_valid && out_ready && out_last_elem, !out_valid || out_elem_index == '0)

  // one word in flight at a time
  `OLPI_ASSERT_NEXT(a_in_one, in_valid && in_ready, !in_ready)

endmodule

bind ordered_list_positional_insert olpi_chk u_olpi_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_elem_index (out_ch.elem_index),
  .out_last_elem  (out_ch.last_elem)
);

// ===== sim/ordered_list_positional_insert_tb.sv =====
`timescale 1ns / 1ps
module ordered_list_positional_insert_tb;
  import olpi_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int USABLE       = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;
  localparam int RANDOM_WORDS = 150;
  localparam int SETTLE       = 40;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_PULSE} rx_mode_t;

  typedef struct {
    logic [VAL_W-1:0]     value;
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
    logic                 rejected;
  } listing_entry_t;

  logic clk;
  logic rst_n;

  olpi_in_if  in_bus ();
  olpi_out_if out_bus ();

  ordered_list_positional_insert #(.CAPACITY(CAPACITY)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  logic [VAL_W-1:0] list_shadow [STORE_DEPTH];
  int               list_len;
  listing_entry_t   listing_q [$];
  int               err_count;
  int               hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // shadow list update plus the listing it produces
  function automatic void apply_insert(input logic [OP_W-1:0] op,
                                       input logic [VAL_W-1:0] val,
                                       input logic [POS_W-1:0] pos);
    int slot;
    int i;
    logic full;
    listing_entry_t e;
    full = (list_len >= USABLE);
    if (!full) begin
      if (op == OP_FRONT) begin
        slot = 0;
      end else if (op == OP_END) begin
        slot = list_len;
      end else if (int'(pos) >= list_len) begin
        slot = list_len;
      end else begin
        slot = int'(pos);
      end
      for (i = list_len; i > slot; i--) list_shadow[i] = list_shadow[i-1];
      list_shadow[slot] = val;
      list_len++;
    end
    for (i = 0; i < list_len; i++) begin
      e.value    = list_shadow[i];
      e.index    = IDX_OUT_W'(i);
      e.last     = (i == list_len - 1);
      e.rejected = full;
      listing_q.push_back(e);
    end
  endfunction

  // valid stays high on return; caller sends again, idles or stops in the same step
  task automatic send_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.item_value <= val;
    in_bus.insert_pos <= pos;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    apply_insert(op, val, pos);
  endtask

  task automatic idle_gap(input int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic stop_offer();
    in_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    stop_offer();
    while (listing_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_edge_inserts();
    send_word(OP_POS,   16'h0000, 8'd0);    // positional into empty list
    send_word(OP_FRONT, 16'hFFFF, 8'd0);
    send_word(OP_POS,   16'h1234, 8'd0);    // index zero goes to front
    send_word(OP_POS,   16'h00FF, 8'd3);    // index equal to length goes to end
    send_word(OP_POS,   16'hAAAA, 8'd255);
    send_word(OP_POS,   16'h5555, 8'd2);
    idle_gap(3);
    send_word(OP_SPARE, 16'h8001, 8'd1);    // spare opcode acts positional
    send_word(OP_SPARE, 16'h7FFE, 8'd200);
    send_word(OP_END,   16'hFF00, 8'd0);    // position ignored
    idle_gap(1);
    send_word(OP_FRONT, 16'h00FF, 8'd255);
    send_word(OP_POS,   16'h0F0F, POS_W'(list_len - 1));
    drain();
  endtask

  task automatic test_random_traffic();
    int n;
    int burst_left;
    logic [OP_W-1:0] op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    burst_left = $urandom_range(1, 6);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      op  = OP_W'($urandom_range(0, 3));
      val = VAL_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) begin
        pos = POS_W'($urandom_range(0, 255));
      end else begin
        pos = POS_W'($urandom_range(0, list_len));
      end
      send_word(op, val, pos);
      burst_left--;
      // back-to-back stretch in the middle of the run
      if (burst_left <= 0 && !(n >= 60 && n < 90)) begin
        idle_gap($urandom_range(1, 20));
        burst_left = $urandom_range(1, 8);
      end
    end
    drain();
  endtask

  task automatic test_full_list();
    send_word(OP_FRONT, 16'h0000, 8'd0);
    send_word(OP_END,   16'hFFFF, 8'd255);
    send_word(OP_POS,   16'h5A5A, 8'd0);
    idle_gap(2);
    send_word(OP_POS,   16'hA5A5, 8'd255);
    send_word(OP_SPARE, 16'h8000, 8'd7);
    drain();
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_backpressure_fill();
    int n;
    hold_left = 400;
    for (n = 0; n < 6; n++) begin
      send_word(OP_W'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 65535)),
                POS_W'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin : rx_pacer
    rx_mode_t mode;
    int mode_left;
    int phase;
    mode      = RX_OPEN;
    mode_left = 60;
    phase     = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:   out_bus.ready <= 1'b1;
          RX_BUSY:   out_bus.ready <= ($urandom_range(0, 3) != 0);
          RX_CHOKED: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   out_bus.ready <= ((phase % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : listing_check
    listing_entry_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (listing_q.size() == 0) begin
        err_count++;
        $display("%0t unexpected word: expected none, actual value=%h idx=%0d last=%b rej=%b",
                 $realtime, out_bus.elem_value, out_bus.elem_index, out_bus.last_elem,
                 out_bus.insert_rejected);
      end else begin
        want = listing_q.pop_front();
        if (want.value !== out_bus.elem_value || want.index !== out_bus.elem_index ||
            want.last !== out_bus.last_elem || want.rejected !== out_bus.insert_rejected) begin
          err_count++;
          $display("%0t mismatch: expected value=%h idx=%0d last=%b rej=%b,",
                   $realtime, want.value, want.index, want.last, want.rejected,
                   " actual value=%h idx=%0d last=%b rej=%b",
                   out_bus.elem_value, out_bus.elem_index, out_bus.last_elem,
                   out_bus.insert_rejected);
        end
      end
    end
  end

  initial begin
    err_count  = 0;
    hold_left  = 0;
    list_len   = 0;
    foreach (list_shadow[i]) list_shadow[i] = '0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_FRONT;
    in_bus.item_value <= '0;
    in_bus.insert_pos <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_inserts();
    test_random_traffic();
    test_full_list();
    test_backpressure_fill();
    if (err_count == 0 && listing_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
